FILE: src/mabr_pkg.sv
package mabr_pkg;

  // Default row capacity and the fixed field widths
  localparam int MAX_ROW_PIXELS_DEF = 1024;
  localparam int QUEUE_DEPTH        = 4;
  localparam int ROW_WIDTH_W        = 11;
  localparam int CFG_DATA_W         = 16;
  localparam int PIXEL_W            = 32;

  // Row width after reset
  localparam logic [ROW_WIDTH_W-1:0] ROW_WIDTH_RESET = 11'd1024;

  // 255.0 in unsigned 8.8
  localparam logic [15:0] WEIGHT_MAX = 16'd65280;

  typedef enum logic [0:0] {
    CMD_PIXEL = 1'b0,
    CMD_DRAIN = 1'b1
  } cmd_t;

  typedef enum logic [0:0] {
    REG_ROW_WIDTH    = 1'b0,
    REG_BLEND_WEIGHT = 1'b1
  } cfg_reg_t;

  // One blend job: source and mirror pixel, clamped weight, end of row
  typedef struct packed {
    logic [PIXEL_W-1:0] src;
    logic [PIXEL_W-1:0] mir;
    logic [15:0]        weight;
    logic               last;
  } mabr_job_t;

endpackage

FILE: src/mabr_ram.sv
module mabr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, two registered read ports
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

FILE: src/mabr_front.sv
module mabr_front import mabr_pkg::*; #(
  parameter int MAX_ROW_PIXELS = MAX_ROW_PIXELS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [0:0]            cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  cmd,
  input  logic [PIXEL_W-1:0]    pixel_in,
  input  logic                  pop,
  output logic                  push,
  output mabr_job_t             job
);

  localparam int COL_W  = $clog2(MAX_ROW_PIXELS);
  localparam int CNT_W  = $clog2(MAX_ROW_PIXELS + 1);
  localparam int EXT_W  = (CNT_W > ROW_WIDTH_W) ? CNT_W : ROW_WIDTH_W;
  localparam int DEPTH  = 2 * MAX_ROW_PIXELS;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int RES_W  = $clog2(QUEUE_DEPTH + 1);

  logic [ROW_WIDTH_W-1:0] row_width;
  logic [15:0]            blend_weight;
  logic [COL_W-1:0]       write_column, write_column_next;
  logic                   write_bank, write_bank_next;
  logic [COL_W-1:0]       read_column, read_column_next;
  logic                   row_pending, row_pending_next;
  logic [RES_W-1:0]       reserved, reserved_next;
  logic                   rd_valid;
  logic                   rd_last;
  logic [15:0]            rd_weight;

  logic [EXT_W-1:0]  rw_ext;
  logic [CNT_W-1:0]  eff_width, width_m1;
  logic [CNT_W-1:0]  wcol, rcol, mcol;
  logic              w_last, r_last;
  logic [15:0]       weight_sat;
  logic              accept, emit, wr;
  logic [ADDR_W-1:0] waddr, saddr, maddr;
  logic [ADDR_W-1:0] wbase, rbase;
  logic [PIXEL_W-1:0] rdata_s, rdata_m;

  // Effective width saturated to 1..MAX_ROW_PIXELS
  assign rw_ext = EXT_W'(row_width);
  always_comb begin
    if (rw_ext == '0) begin
      eff_width = CNT_W'(1);
    end else if (rw_ext > EXT_W'(MAX_ROW_PIXELS)) begin
      eff_width = CNT_W'(MAX_ROW_PIXELS);
    end else begin
      eff_width = CNT_W'(rw_ext);
    end
  end
  assign width_m1 = eff_width - CNT_W'(1);

  // Columns saturated to the current width
  assign wcol   = (CNT_W'(write_column) >= eff_width) ? width_m1 : CNT_W'(write_column);
  assign rcol   = (CNT_W'(read_column) >= eff_width) ? width_m1 : CNT_W'(read_column);
  assign mcol   = width_m1 - rcol;
  assign w_last = (wcol == width_m1);
  assign r_last = (rcol == width_m1);

  assign weight_sat = (blend_weight > WEIGHT_MAX) ? WEIGHT_MAX : blend_weight;

  // Handshake: room is reserved in the queue for every read in flight
  assign in_ready = (reserved < RES_W'(QUEUE_DEPTH));
  assign accept   = in_valid && in_ready;
  assign emit     = accept && row_pending;
  assign wr       = accept && (cmd == CMD_PIXEL);

  // Row store addressing: write bank and the completed (other) bank
  assign wbase = write_bank ? ADDR_W'(MAX_ROW_PIXELS) : '0;
  assign rbase = write_bank ? '0 : ADDR_W'(MAX_ROW_PIXELS);
  assign waddr = wbase + ADDR_W'(wcol);
  assign saddr = rbase + ADDR_W'(rcol);
  assign maddr = rbase + ADDR_W'(mcol);

  mabr_ram #(
    .WIDTH(PIXEL_W),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk     (clk),
    .we      (wr),
    .waddr   (waddr),
    .wdata   (pixel_in),
    .re      (emit),
    .raddr_a (saddr),
    .raddr_b (maddr),
    .rdata_a (rdata_s),
    .rdata_b (rdata_m)
  );

  // Row tracking: emit from the pending row first, then write the pixel
  always_comb begin
    write_column_next = write_column;
    write_bank_next   = write_bank;
    read_column_next  = read_column;
    row_pending_next  = row_pending;
    if (emit) begin
      if (r_last) begin
        row_pending_next = 1'b0;
        read_column_next = '0;
      end else begin
        read_column_next = COL_W'(rcol + CNT_W'(1));
      end
    end
    if (wr) begin
      if (w_last) begin
        write_column_next = '0;
        write_bank_next   = ~write_bank;
        row_pending_next  = 1'b1;
        read_column_next  = '0;
      end else begin
        write_column_next = COL_W'(wcol + CNT_W'(1));
      end
    end
  end

  assign reserved_next = reserved + RES_W'(emit) - RES_W'(pop);

  always_ff @(posedge clk) begin
    if (rst) begin
      row_width    <= ROW_WIDTH_RESET;
      blend_weight <= '0;
      write_column <= '0;
      write_bank   <= 1'b0;
      read_column  <= '0;
      row_pending  <= 1'b0;
      reserved     <= '0;
      rd_valid     <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_ROW_WIDTH:    row_width    <= cfg_data[ROW_WIDTH_W-1:0];
          REG_BLEND_WEIGHT: blend_weight <= cfg_data[15:0];
          default:          ;
        endcase
      end
      write_column <= write_column_next;
      write_bank   <= write_bank_next;
      read_column  <= read_column_next;
      row_pending  <= row_pending_next;
      reserved     <= reserved_next;
      rd_valid     <= emit;
    end
  end

  // Job side data travels alongside the registered read
  always_ff @(posedge clk) begin
    if (emit) begin
      rd_last   <= r_last;
      rd_weight <= weight_sat;
    end
  end

  assign push       = rd_valid;
  assign job.src    = rdata_s;
  assign job.mir    = rdata_m;
  assign job.weight = rd_weight;
  assign job.last   = rd_last;

endmodule

FILE: src/mabr_queue.sv
module mabr_queue import mabr_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  mabr_job_t job_in,
  input  logic      pop,
  output logic      job_valid,
  output mabr_job_t job_out
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  mabr_job_t        entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;

  assign job_valid = (count != '0);
  assign job_out   = entries[rd_ptr];

  // Pointers wrap at DEPTH; the front never pushes into a full queue
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      count <= count + CNT_W'(push) - CNT_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= job_in;
    end
  end

endmodule

FILE: src/mabr_back.sv
module mabr_back import mabr_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               job_valid,
  input  mabr_job_t          job,
  output logic               take,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [PIXEL_W-1:0] pixel_out,
  output logic               row_end
);

  logic        a_valid;
  logic [23:0] a_num [3];
  logic [7:0]  a_alpha;
  logic        a_last;

  logic               out_adv, a_ready;
  logic [23:0]        num [3];
  logic [7:0]         src_b [3];
  logic [7:0]         mir_b [3];
  logic signed [8:0]  diff [3];
  logic signed [25:0] prod [3];
  logic [25:0]        base [3];
  logic [15:0]        quo [3];
  logic [15:0]        est_sum [3];
  logic [7:0]         est [3];
  logic [15:0]        rem [3];
  logic [7:0]         res_b [3];

  // Stage flow control
  assign out_adv = !out_valid || out_ready;
  assign a_ready = !a_valid || out_adv;
  assign take    = job_valid && a_ready;

  // Stage A: num = s*65280 + w*(m - s), one small multiply per lane
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      src_b[k] = job.src[8*k +: 8];
      mir_b[k] = job.mir[8*k +: 8];
      diff[k]  = $signed({1'b0, mir_b[k]}) - $signed({1'b0, src_b[k]});
      prod[k]  = $signed({1'b0, job.weight}) * diff[k];
      base[k]  = {2'b00, src_b[k], 16'h0000} - {10'h000, src_b[k], 8'h00};
      num[k]   = 24'(base[k] + $unsigned(prod[k]));
    end
  end

  // Stage B: divide by 65280 as >>8 then /255 with one correction step
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      quo[k]     = a_num[k][23:8];
      est_sum[k] = quo[k] + {8'h00, quo[k][15:8]};
      est[k]     = est_sum[k][15:8];
      rem[k]     = quo[k] - ({est[k], 8'h00} - {8'h00, est[k]});
      res_b[k]   = (rem[k] >= 16'd255) ? est[k] + 8'd1 : est[k];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (a_ready) begin
        a_valid <= job_valid;
      end
      if (out_adv) begin
        out_valid <= a_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      a_num   <= num;
      a_alpha <= job.mir[31:24];
      a_last  <= job.last;
    end
    if (out_adv && a_valid) begin
      pixel_out <= {a_alpha, res_b[2], res_b[1], res_b[0]};
      row_end   <= a_last;
    end
  end

endmodule

FILE: src/mirror_alpha_blend_row_unit.sv
// Horizontal mirror alpha blend over BGRA rows.
//
// Input channel (in_valid / in_ready, cmd, pixel_in): a pixel transaction
// (cmd = 0) is written into the write half of a ping-pong row store; a drain
// transaction (cmd = 1) carries no pixel. Every input transaction that finds a
// completed row yields one result from that row, column by column, blended
// with the pixel at the mirrored column; row_end marks its last pixel.
// Output channel (out_valid / out_ready, pixel_out, row_end).
// Configuration: cfg_we writes cfg_data into register cfg_index
// (0 = row_width, 1 = blend_weight) at the clock edge; write only when idle.
//
// Throughput: one transaction per clock while in_ready is high. A result
// reaches the output through the row store read, the queue, the multiply
// stage and the divide stage into the output register.
// A four-entry job queue between the row store and the blend pipeline lets
// the input keep moving while a result waits; once it is full, in_ready drops.
// Reset (rst, synchronous) clears the row state and pipeline and restores
// row_width = 1024 and blend_weight = 0; the row store holds no reset value.
module mirror_alpha_blend_row_unit import mabr_pkg::*; #(
  parameter int MAX_ROW_PIXELS = MAX_ROW_PIXELS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [0:0]            cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  cmd,
  input  logic [PIXEL_W-1:0]    pixel_in,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [PIXEL_W-1:0]    pixel_out,
  output logic                  row_end
);

  logic      push, pop, job_valid;
  mabr_job_t job_front, job_back;

  // Front: row bookkeeping and row store access
  mabr_front #(
    .MAX_ROW_PIXELS(MAX_ROW_PIXELS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .cmd       (cmd),
    .pixel_in  (pixel_in),
    .pop       (pop),
    .push      (push),
    .job       (job_front)
  );

  // Job queue
  mabr_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .job_in    (job_front),
    .pop       (pop),
    .job_valid (job_valid),
    .job_out   (job_back)
  );

  // Back: blend pipeline and output register
  mabr_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job_valid (job_valid),
    .job       (job_back),
    .take      (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .pixel_out (pixel_out),
    .row_end   (row_end)
  );

endmodule

FILE: src/mabr_checker.sv
module mabr_checker import mabr_pkg::*; (
  input logic                  clk,
  input logic                  rst,
  input logic                  cfg_we,
  input logic [0:0]            cfg_index,
  input logic [CFG_DATA_W-1:0] cfg_data,
  input logic                  in_valid,
  input logic                  in_ready,
  input logic                  out_valid,
  input logic                  out_ready,
  input logic [PIXEL_W-1:0]    pixel_out,
  input logic                  row_end
);

  logic [ROW_WIDTH_W-1:0] width_shadow;
  logic [15:0]            balance;
  logic                   in_xact, out_xact, narrow_row;

  assign in_xact    = in_valid && in_ready;
  assign out_xact   = out_valid && out_ready;
  assign narrow_row = (width_shadow <= ROW_WIDTH_W'(1));

  // Shadow of row_width and a count of input minus output transactions
  always_ff @(posedge clk) begin
    if (rst) begin
      width_shadow <= ROW_WIDTH_RESET;
      balance      <= '0;
    end else begin
      if (cfg_we && (cfg_index == REG_ROW_WIDTH)) begin
        width_shadow <= cfg_data[ROW_WIDTH_W-1:0];
      end
      if (in_xact && !out_xact && (balance != 16'hFFFF)) begin
        balance <= balance + 16'd1;
      end else if (!in_xact && out_xact && (balance != '0)) begin
        balance <= balance - 16'd1;
      end
    end
  end

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(pixel_out) && $stable(row_end))
    else $error("result changed while stalled");

  // Reset empties the output
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  // No result without an input transaction that caused it
  a_no_invented: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> balance != '0)
    else $error("result without a preceding input transaction");

  // Rows of one pixel end on every result
  a_narrow_end: assert property (@(posedge clk) disable iff (rst)
    out_valid && narrow_row |-> row_end)
    else $error("one pixel row without row_end");

endmodule

bind mirror_alpha_blend_row_unit mabr_checker u_mabr_checker (
  .clk       (clk),
  .rst       (rst),
  .cfg_we    (cfg_we),
  .cfg_index (cfg_index),
  .cfg_data  (cfg_data),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .pixel_out (pixel_out),
  .row_end   (row_end)
);

FILE: test/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import mabr_pkg::*;

  localparam int ROW_CAP    = MAX_ROW_PIXELS_DEF;
  localparam int WIDE_ROW   = ROW_CAP / 2;
  localparam int SETTLE     = 8;     // pipeline latency plus margin
  localparam int LONG_HOLD  = 60;    // receiver back-pressure stretch
  localparam int STALL_STOP = 2000;  // cycles with no transaction before giving up

  typedef struct {
    logic [PIXEL_W-1:0] pixel;
    logic               last;
  } blend_result_t;

  // Mirror-blend predictor plus queue of pending output transactions
  class row_blend_board;
    logic [PIXEL_W-1:0] store [0:2*ROW_CAP-1];
    bit                 written [0:2*ROW_CAP-1];
    int                 write_col;
    bit                 write_bank;
    int                 read_col;
    bit                 pending;
    logic [10:0]        width_reg;
    logic [15:0]        weight_reg;
    blend_result_t      expected_pixels [$];
    int                 errors;

    function new();
      foreach (written[i]) written[i] = 1'b0;
      write_col  = 0;
      write_bank = 1'b0;
      read_col   = 0;
      pending    = 1'b0;
      width_reg  = ROW_WIDTH_RESET;
      weight_reg = '0;
      errors     = 0;
    endfunction

    function int eff_of(logic [10:0] v);
      if (v == 0) return 1;
      if (v > ROW_CAP) return ROW_CAP;
      return int'(v);
    endfunction

    // True when the completed row's bank holds data in columns 0..w-1
    function bit row_readable(int w);
      int base;
      base = (write_bank ? 0 : ROW_CAP);
      for (int i = 0; i < w; i++)
        if (!written[base + i]) return 1'b0;
      return 1'b1;
    endfunction

    function void set_reg(cfg_reg_t idx, logic [15:0] v);
      if (idx == REG_ROW_WIDTH) width_reg = v[10:0];
      else weight_reg = v;
    endfunction

    function logic [7:0] blend_chan(logic [7:0] s, logic [7:0] m, logic [15:0] w);
      int unsigned num;
      num = s * (WEIGHT_MAX - w) + m * w;
      return 8'(num / WEIGHT_MAX);
    endfunction

    // One output pixel from the completed row, blended with its mirror
    function void emit_mirrored(int width);
      int            base, c;
      logic [15:0]   w;
      logic [31:0]   s, m;
      blend_result_t r;
      base = (write_bank ? 0 : ROW_CAP);
      c = (read_col >= width) ? width - 1 : read_col;
      w = (weight_reg > WEIGHT_MAX) ? WEIGHT_MAX : weight_reg;
      s = store[base + c];
      m = store[base + width - 1 - c];
      r.pixel[31:24] = m[31:24];
      for (int k = 0; k < 3; k++)
        r.pixel[8*k +: 8] = blend_chan(s[8*k +: 8], m[8*k +: 8], w);
      r.last = (c + 1 >= width);
      expected_pixels.push_back(r);
      if (r.last) begin
        pending  = 1'b0;
        read_col = 0;
      end else begin
        read_col = c + 1;
      end
    endfunction

    function void note_input(cmd_t c, logic [PIXEL_W-1:0] pix);
      int width, col, addr;
      width = eff_of(width_reg);
      if (pending) emit_mirrored(width);
      if (c == CMD_PIXEL) begin
        col  = (write_col >= width) ? width - 1 : write_col;
        addr = (write_bank ? ROW_CAP : 0) + col;
        store[addr]   = pix;
        written[addr] = 1'b1;
        if (col + 1 >= width) begin
          write_col  = 0;
          write_bank = ~write_bank;
          pending    = 1'b1;
          read_col   = 0;
        end else begin
          write_col = col + 1;
        end
      end
    endfunction

    function void check_pixel(logic [PIXEL_W-1:0] pix, logic last);
      blend_result_t want;
      if (expected_pixels.size() == 0) begin
        $error("unexpected result: pixel_out=%h row_end=%b", pix, last);
        errors++;
        return;
      end
      want = expected_pixels.pop_front();
      if (pix !== want.pixel) begin
        $error("pixel_out: expected %h, got %h", want.pixel, pix);
        errors++;
      end
      if (last !== want.last) begin
        $error("row_end: expected %b, got %b", want.last, last);
        errors++;
      end
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_we = 1'b0;
  cfg_reg_t              cfg_index = REG_ROW_WIDTH;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  cmd_t                  cmd = CMD_PIXEL;
  logic [PIXEL_W-1:0]    pixel_in = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [PIXEL_W-1:0]    pixel_out;
  logic                  row_end;

  row_blend_board board = new();
  int send_gap_pct  = 0;
  int recv_idle_pct = 0;
  int hold_req  = 0;
  int hold_done = 0;
  int quiet_cycles = 0;

  mirror_alpha_blend_row_unit DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .cmd       (cmd),
    .pixel_in  (pixel_in),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .pixel_out (pixel_out),
    .row_end   (row_end)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Transaction monitor: check results, then feed accepted inputs to the predictor
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) board.check_pixel(pixel_out, row_end);
      if (in_valid && in_ready) board.note_input(cmd, pixel_in);
    end
  end

  // Watchdog on cycles with no transaction on either channel
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_STOP) begin
      $display("*** FAILED ***");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Output side: random back-pressure, plus a long hold on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_done != hold_req) begin
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        hold_done++;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  task automatic send_item(input cmd_t c, input logic [PIXEL_W-1:0] pix);
    while ($urandom_range(0, 99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    cmd      <= c;
    pixel_in <= pix;
    do @(posedge clk); while (!in_ready);
  endtask

  // Stop offering input and wait for every expected result
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (board.expected_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic configure(input logic [10:0] width, input logic [15:0] weight);
    int grown;
    wait_drained();
    grown = board.eff_of(width);
    // a wider width over a pending row must not reach never-written columns
    if (board.pending && grown > board.eff_of(board.width_reg) &&
        !board.row_readable(grown)) begin
      while (board.pending) begin
        send_item(CMD_DRAIN, $urandom());
        wait_drained();
      end
    end
    cfg_we    <= 1'b1;
    cfg_index <= REG_ROW_WIDTH;
    cfg_data  <= 16'(width);
    @(posedge clk);
    board.set_reg(REG_ROW_WIDTH, 16'(width));
    cfg_index <= REG_BLEND_WEIGHT;
    cfg_data  <= weight;
    @(posedge clk);
    board.set_reg(REG_BLEND_WEIGHT, weight);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [10:0] pick_width();
    case ($urandom_range(0, 9))
      0:       return 11'd0;
      1:       return 11'd2047;
      2:       return 11'd1024;
      3, 4:    return 11'($urandom_range(9, 40));
      default: return 11'($urandom_range(1, 8));
    endcase
  endfunction

  function automatic logic [15:0] pick_weight();
    case ($urandom_range(0, 4))
      0:       return 16'd0;
      1:       return WEIGHT_MAX;
      2:       return 16'hFFFF;
      default: return 16'($urandom());
    endcase
  endfunction

  function automatic logic [PIXEL_W-1:0] pick_pixel();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return $urandom();
    endcase
  endfunction

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Width 0 acts as 1; weight above 255.0 saturates; drain with nothing pending
    configure(11'd0, 16'hFFFF);
    send_item(CMD_PIXEL, 32'hFFFFFFFF);
    send_item(CMD_PIXEL, 32'h00000000);
    send_item(CMD_DRAIN, 32'hFFFFFFFF);
    send_item(CMD_DRAIN, 32'h00000000);

    // Drain inside a partial row, then a new row overlapping the emitted one
    configure(11'd4, 16'h8000);
    send_item(CMD_PIXEL, 32'h00000000);
    send_item(CMD_PIXEL, 32'hFFFFFFFF);
    send_item(CMD_PIXEL, 32'h80FF007F);
    send_item(CMD_DRAIN, 32'h5A5A5A5A);
    send_item(CMD_PIXEL, 32'h00FF00FF);
    send_item(CMD_DRAIN, 32'h00000000);
    send_item(CMD_PIXEL, 32'h12345678);
    send_item(CMD_PIXEL, 32'hFF00FF00);

    // Width lowered with a row pending and a partial row in progress
    configure(11'd2, WEIGHT_MAX);
    send_item(CMD_PIXEL, 32'hA5A55A5A);
    send_item(CMD_DRAIN, 32'h00000000);
    send_item(CMD_DRAIN, 32'h00000000);
    send_item(CMD_DRAIN, 32'h00000000);

    // Random phases under three idling patterns
    for (int mode = 0; mode < 3; mode++) begin
      send_gap_pct  = (mode == 0) ? 26 : (mode == 1) ? 78 : 0;
      recv_idle_pct = (mode == 0) ? 78 : (mode == 1) ? 26 : 0;
      if (mode == 2) begin
        // long output hold while pixels keep coming: the queue fills up
        configure(11'd3, pick_weight());
        hold_req++;
        repeat (40) send_item(CMD_PIXEL, pick_pixel());
      end
      for (int ph = 0; ph < 5; ph++) begin
        configure(pick_width(), pick_weight());
        repeat (28) begin
          send_item(cmd_t'(($urandom_range(0, 99) < 15) ? CMD_DRAIN : CMD_PIXEL),
                    pick_pixel());
        end
      end
    end

    // One wide row, then the width cut while it is pending
    configure(11'(WIDE_ROW), pick_weight());
    repeat (WIDE_ROW) send_item(CMD_PIXEL, pick_pixel());
    configure(11'd3, pick_weight());
    repeat (12) send_item(CMD_PIXEL, pick_pixel());
    send_item(CMD_DRAIN, pick_pixel());
    send_item(CMD_DRAIN, pick_pixel());

    wait_drained();
    if (board.expected_pixels.size() != 0) begin
      $error("%0d results never arrived", board.expected_pixels.size());
      board.errors++;
    end
    if (board.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
